// ----- design/wfrm_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the windowed flow rate meter
// no dependencies

package wfrm_pkg;

   localparam int COUNT_W   = 32;
   localparam int TIME_W    = 48;
   localparam int RATE_W    = 32;
   localparam int PB_W      = 16;
   localparam int MS_W      = 10;
   localparam int PBK_W     = PB_W + MS_W;
   localparam int PROD_W    = PBK_W + COUNT_W;
   localparam int STEP_W    = $clog2(PROD_W + 1);
   localparam int CSR_W     = TIME_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [MS_W-1:0] MS_PER_S           = MS_W'(1000);
   localparam logic [PB_W-1:0] PACKET_BYTES_RESET = PB_W'(1048);
   localparam int              WINDOW_DEFAULT     = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PACKET_BYTES = 1'b0,
      CSR_START_TIME   = 1'b1
   } csr_idx_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic delta;
      logic scale;
      logic div_rate_go;
      logic take_rate;
      logic update;
      logic div_mean_go;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;
      logic div_busy;
      logic rsp_busy;
   } sts_type;

endpackage

// ----- design/wfrm_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module wfrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 5
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/wfrm_divider.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, shared for rate and mean
// depends on wfrm_pkg

module wfrm_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wfrm_pkg::PROD_W-1:0]   dividend,
   input  logic [wfrm_pkg::TIME_W-1:0]   divisor,
   input  logic [wfrm_pkg::STEP_W-1:0]   steps,
   output logic                          busy,
   output logic [wfrm_pkg::PROD_W-1:0]   quotient
);
   import wfrm_pkg::*;

   logic                act_ff, act_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W:0]     rem_ff, rem_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [TIME_W-1:0]   div_ff, div_in;
   logic [TIME_W:0]     trial;
   logic                fits;

   assign trial = {rem_ff[TIME_W-1:0], quo_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (start) begin
         act_in = 1'b1;
         cnt_in = steps;
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (act_ff) begin
         rem_in = fits ? (trial - {1'b0, div_ff}) : trial;
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            act_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = act_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/wfrm_datapath.sv -----
`timescale 1ns / 1ps
// datapath: config registers, interval math, rate ring, running sum, output register
// depends on wfrm_pkg, wfrm_ram, wfrm_divider

module wfrm_datapath #(
   parameter int WINDOW = wfrm_pkg::WINDOW_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wfrm_pkg::cmd_type                     cmd,
   output wfrm_pkg::sts_type                     sts,
   input  logic [wfrm_pkg::COUNT_W+wfrm_pkg::TIME_W-1:0] req_tdata,
   output logic [wfrm_pkg::RATE_W-1:0]           rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [wfrm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wfrm_pkg::CSR_W-1:0]            csr_wdata
);
   import wfrm_pkg::*;

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = RATE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

   // config
   logic [PB_W-1:0]    pb_ff, pb_in;

   // per flow state
   logic [COUNT_W-1:0] prev_cnt_ff, prev_cnt_in;
   logic [TIME_W-1:0]  prev_time_ff, prev_time_in;
   logic [PTR_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   // working registers
   logic [COUNT_W-1:0] cnt_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [COUNT_W-1:0] dc_ff;
   logic [TIME_W-1:0]  dt_ff;
   logic               bad_ff;
   logic [PBK_W-1:0]   pbk_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [RATE_W-1:0]  rate_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rsp_data_ff;
   logic               rsp_bad_ff;

   logic [RATE_W-1:0]  old_rate;
   logic [SUM_W:0]     sum_add;
   logic               div_go;
   logic [PROD_W-1:0]  div_dividend;
   logic [TIME_W-1:0]  div_divisor;
   logic [STEP_W-1:0]  div_steps;
   logic               div_busy;
   logic [PROD_W-1:0]  quo;

   wfrm_ram #(
      .WIDTH (RATE_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (cmd.update),
      .waddr (pos_ff),
      .wdata (rate_ff),
      .raddr (pos_ff),
      .rdata (old_rate)
   );

   // rate division or mean division, never both at once
   assign div_go       = cmd.div_rate_go | cmd.div_mean_go;
   assign div_dividend = cmd.div_mean_go ? {sum_ff, {(PROD_W - SUM_W){1'b0}}} : prod_ff;
   assign div_divisor  = cmd.div_mean_go ? TIME_W'(fill_ff) : dt_ff;
   assign div_steps    = cmd.div_mean_go ? STEP_W'(SUM_W) : STEP_W'(PROD_W);

   wfrm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (quo)
   );

   // running window sum, oldest slot drops out once full
   assign sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(rate_ff)
                  - ((fill_ff == FULL_CNT) ? (SUM_W + 1)'(old_rate) : '0);

   always_comb begin
      pb_in        = pb_ff;
      prev_cnt_in  = prev_cnt_ff;
      prev_time_in = prev_time_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PACKET_BYTES: pb_in = csr_wdata[PB_W-1:0];
            CSR_START_TIME: begin
               // the start time only matters as the first reference
               if (fill_ff == '0) begin
                  prev_time_in = csr_wdata;
               end
            end
            default: ;
         endcase
      end
      if (cmd.update) begin
         sum_in       = sum_add[SUM_W-1:0];
         pos_in       = (pos_ff == LAST_POS) ? '0 : pos_ff + PTR_W'(1);
         fill_in      = (fill_ff == FULL_CNT) ? fill_ff : fill_ff + CNT_W'(1);
         prev_cnt_in  = cnt_ff;
         prev_time_in = now_ff;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_ff        <= PACKET_BYTES_RESET;
         prev_cnt_ff  <= '0;
         prev_time_ff <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pb_ff        <= pb_in;
         prev_cnt_ff  <= prev_cnt_in;
         prev_time_ff <= prev_time_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cnt_ff <= req_tdata[COUNT_W-1:0];
         now_ff <= req_tdata[COUNT_W+TIME_W-1:COUNT_W];
      end
      if (cmd.delta) begin
         dc_ff  <= cnt_ff - prev_cnt_ff;
         dt_ff  <= now_ff - prev_time_ff;
         bad_ff <= (now_ff <= prev_time_ff) || (cnt_ff < prev_cnt_ff);
         pbk_ff <= PBK_W'(pb_ff) * PBK_W'(MS_PER_S);
      end
      if (cmd.scale) begin
         prod_ff <= PROD_W'(pbk_ff) * PROD_W'(dc_ff);
      end
      if (cmd.take_rate) begin
         if (bad_ff) begin
            rate_ff <= '0;
         end else if (|quo[PROD_W-1:RATE_W]) begin
            rate_ff <= '1;
         end else begin
            rate_ff <= quo[RATE_W-1:0];
         end
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= quo[RATE_W-1:0];
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign sts.bad      = bad_ff;
   assign sts.div_busy = div_busy;
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- design/wfrm_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences one request through the datapath
// depends on wfrm_pkg

module wfrm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  wfrm_pkg::sts_type sts,
   output wfrm_pkg::cmd_type cmd
);
   import wfrm_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_DELTA     = 10'b00_0000_0010,
      S_SCALE     = 10'b00_0000_0100,
      S_DIVR_GO   = 10'b00_0000_1000,
      S_DIVR      = 10'b00_0001_0000,
      S_RATE      = 10'b00_0010_0000,
      S_UPDATE    = 10'b00_0100_0000,
      S_DIVM_GO   = 10'b00_1000_0000,
      S_DIVM      = 10'b01_0000_0000,
      S_OUT       = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = sts.bad ? S_RATE : S_DIVR_GO;
         end
         S_DIVR_GO: begin
            cmd.div_rate_go = 1'b1;
            state_in        = S_DIVR;
         end
         S_DIVR: begin
            if (!sts.div_busy) begin
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            cmd.take_rate = 1'b1;
            state_in      = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_DIVM_GO;
         end
         S_DIVM_GO: begin
            cmd.div_mean_go = 1'b1;
            state_in        = S_DIVM;
         end
         S_DIVM: begin
            if (!sts.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/windowed_flow_rate_meter.sv -----
`timescale 1ns / 1ps
// top level of the windowed flow rate meter
// depends on wfrm_pkg, wfrm_ctrl, wfrm_datapath

// Each request carries a flow's cumulative packet count and a millisecond
// timestamp. The block turns the interval since the previous request into a
// byte rate, floor(packet_bytes * 1000 * delta_count / delta_ms), saturated to
// 32 bits, puts it in a ring of WINDOW slots and answers with the truncated
// mean over the slots filled so far (over all WINDOW once the ring is full).
// A non-positive time delta or a count that goes backwards records rate 0 and
// sets the bad_interval flag in rsp_tuser. One request is worked at a time,
// through a single restoring divider, one quotient bit per cycle, shared
// between the 58-bit rate division and the SUM_W-bit mean division, where
// SUM_W = 32 + ceil(log2(WINDOW)); a bad interval skips the rate division.
// The result sits in an output register, so the next request is accepted
// the cycle after the result is loaded, while it waits; a new result is only
// loaded once the previous one has been taken, so a stalled receiver holds
// up the block.
// Configuration: index 0 packet_bytes, index 1 start_time_ms; writing the
// start time also sets the previous timestamp while the ring is still empty.

module windowed_flow_rate_meter #(
   parameter int WINDOW = wfrm_pkg::WINDOW_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pkt_total [31:0], now_ms [79:32]
   input  logic [wfrm_pkg::COUNT_W+wfrm_pkg::TIME_W-1:0] req_tdata,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // average_rate [31:0]
   output logic [wfrm_pkg::RATE_W-1:0]           rsp_tdata,
   // bad_interval [0]
   output logic                                  rsp_tuser,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [wfrm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wfrm_pkg::CSR_W-1:0]            csr_wdata
);
   import wfrm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer for capture, deltas, scaling, divisions and result load
   wfrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // arithmetic, ring storage, config registers and response register
   wfrm_datapath #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule
